// ===== src/nwsp_pkg.sv =====
// Shared types, character codes, constants and helper functions of the wind sentence parser.
package nwsp_pkg;

  localparam int unsigned MAX_LEN_DEF     = 100;
  localparam int unsigned FRAC_DIGITS_DEF = 3;

  localparam int unsigned ACC_W   = 27;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned SPEED_W = 26;
  localparam int unsigned ANGLE_W = 12;
  localparam int unsigned BASE_W  = 28;

  localparam logic [ACC_W-1:0]   ACC_MAX   = '1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;
  localparam logic [BASE_W-1:0]  BASE_MAX  = '1;
  localparam logic [POS_W-1:0]   POS_SAT   = '1;

  // Kilometres per hour: (5 * base + 9) / 18 by reciprocal multiplication.
  localparam int unsigned      K_NUM_W  = 31;
  localparam int unsigned      K_SCALE  = 5;
  localparam int unsigned      K_ROUND  = 9;
  localparam int unsigned      K_DIV    = 18;
  localparam int unsigned      K_SHIFT  = K_NUM_W + $clog2(K_DIV);
  localparam longint unsigned  K_MUL    = ((64'd1 << K_SHIFT) + K_DIV - 1) / K_DIV;
  localparam int unsigned      K_MUL_W  = 32;
  localparam int unsigned      K_PROD_W = K_NUM_W + K_MUL_W;

  // Knots: (base + floor(281 * base / 9719) + 1) / 2 equals (10000 * base + 9719) / 19438.
  localparam int unsigned      N_GAIN   = 281;
  localparam int unsigned      N_DIV    = 9719;
  localparam int unsigned      NR_W     = 36;
  localparam int unsigned      NR_HALF  = NR_W / 2;
  localparam int unsigned      N_SHIFT  = NR_W + $clog2(N_DIV);
  localparam longint unsigned  N_MUL    = ((64'd1 << N_SHIFT) + N_DIV - 1) / N_DIV;
  localparam int unsigned      N_MUL_W  = 37;
  localparam int unsigned      N_PP_W   = NR_HALF + N_MUL_W;
  localparam int unsigned      N_SUM_W  = NR_W + N_MUL_W + 1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_R      = "R";
  localparam logic [7:0] CH_M      = "M";
  localparam logic [7:0] CH_K      = "K";
  localparam logic [7:0] CH_N      = "N";
  localparam logic [7:0] CH_A      = "A";
  localparam logic [7:0] CH_V      = "V";

  localparam logic [1:0] UNIT_M = 2'd0;
  localparam logic [1:0] UNIT_K = 2'd1;
  localparam logic [1:0] UNIT_N = 2'd2;

  typedef enum logic [3:0] {
    PH_HEAD,
    PH_A_FIRST,
    PH_A_NUM,
    PH_REF,
    PH_REF_COMMA,
    PH_S_FIRST,
    PH_S_NUM,
    PH_UNIT,
    PH_UNIT_COMMA,
    PH_STATUS,
    PH_DONE,
    PH_HEX1,
    PH_HEX2,
    PH_TAIL
  } phase_e;

  typedef struct packed {
    logic reject;
    logic not_warn;
    logic alarm;
    logic data_fail;
    logic not_mwv;
  } flags_t;

  typedef struct packed {
    logic ok;
    logic warn;
    logic valid;
    logic alarm;
  } res_flags_t;

  function automatic logic [7:0] warn_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "$";
      4'd1:    ch = "P";
      4'd2:    ch = "E";
      4'd3:    ch = "W";
      4'd4:    ch = "W";
      4'd5:    ch = "T";
      4'd6:    ch = ",";
      4'd7:    ch = "N";
      4'd8:    ch = "O";
      4'd9:    ch = "N";
      4'd10:   ch = "E";
      4'd11:   ch = "*";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] mwv_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0: ch = "M";
      2'd1: ch = "W";
      2'd2: ch = "V";
      2'd3: ch = ",";
    endcase
    return ch;
  endfunction

  // Value of a hex digit in either case; 16 marks a character that is no hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] h;
    if (c >= "0" && c <= "9") begin
      h = 5'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      h = 5'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      h = 5'(c - "a" + 8'd10);
    end else begin
      h = 5'd16;
    end
    return h;
  endfunction

  function automatic logic [ACC_W-1:0] mul10_add(input logic [ACC_W-1:0] v,
                                                 input logic [3:0] d);
    logic [ACC_W+3:0] r;
    r = (ACC_W+4)'(v) * (ACC_W+4)'(10) + (ACC_W+4)'(d);
    return (r > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : r[ACC_W-1:0];
  endfunction

endpackage

// ===== src/nmea_wind_sentence_parser_core.sv =====
// Character-serial parser for NMEA 0183 wind data and wind warning sentences.
// Throughput: one character item per cycle; ready drops only while the output register
// holds a result item that has not been taken.
// A result item enters the four-stage speed and angle conversion pipeline behind the parser
// when its terminating zero byte is accepted, and then moves on to the output register.
// Reset: asynchronous, clears the parser state and every stage valid flag.
module nmea_wind_sentence_parser_core #(
  parameter int unsigned MAX_LEN     = nwsp_pkg::MAX_LEN_DEF,
  parameter int unsigned FRAC_DIGITS = nwsp_pkg::FRAC_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   char_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         accepted_o,
  output logic                         sentence_kind_o,
  output logic                         data_valid_o,
  output logic [nwsp_pkg::SPEED_W-1:0] speed_mm_per_s_o,
  output logic [nwsp_pkg::ANGLE_W-1:0] angle_deg_o,
  output logic                         angle_alarm_o
);

  localparam int unsigned     ACC_W     = nwsp_pkg::ACC_W;
  localparam int unsigned     BASE_W    = nwsp_pkg::BASE_W;
  localparam int unsigned     FRAC_POW  = 10 ** FRAC_DIGITS;
  localparam int unsigned     SPD_SCALE = 10 ** (3 - FRAC_DIGITS);
  localparam int unsigned     SPD_W     = ACC_W + 7;
  localparam int unsigned     ANG_HALF  = FRAC_POW / 2;
  localparam int unsigned     ANG_SHIFT = BASE_W + $clog2(FRAC_POW);
  localparam longint unsigned ANG_MUL   = ((64'd1 << ANG_SHIFT) + FRAC_POW - 1) / FRAC_POW;
  localparam int unsigned     ANG_MUL_W = 30;
  localparam int unsigned     ANG_P_W   = BASE_W + ANG_MUL_W;

  function automatic logic [ACC_W-1:0] pad_frac(input logic [ACC_W-1:0] v,
                                                input logic [1:0] fdc);
    logic [1:0]       k;
    logic [ACC_W+9:0] p;
    k = 2'(FRAC_DIGITS) - fdc;
    unique case (k)
      2'd0: p = (ACC_W+10)'(v);
      2'd1: p = (ACC_W+10)'(v) * (ACC_W+10)'(10);
      2'd2: p = (ACC_W+10)'(v) * (ACC_W+10)'(100);
      2'd3: p = (ACC_W+10)'(v) * (ACC_W+10)'(1000);
    endcase
    return (p > (ACC_W+10)'(nwsp_pkg::ACC_MAX)) ? nwsp_pkg::ACC_MAX : p[ACC_W-1:0];
  endfunction

  logic advance;
  logic in_fire;

  nwsp_pkg::phase_e              phase_q, phase_d;
  logic [nwsp_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [7:0]                    xor_q, xor_d;
  logic [ACC_W-1:0]              acc_q, acc_d;
  logic [1:0]                    fdc_q, fdc_d;
  logic                          point_q, point_d;
  logic [ACC_W-1:0]              ang_raw_q, ang_raw_d;
  logic [ACC_W-1:0]              spd_raw_q, spd_raw_d;
  logic [1:0]                    unit_q, unit_d;
  nwsp_pkg::flags_t              flags_q, flags_d;

  logic                          job_fire;
  nwsp_pkg::res_flags_t          job_flags;

  logic                          v0_q, v1_q, v2_q, v3_q, out_valid_q;
  nwsp_pkg::res_flags_t          f0_q, f1_q, f2_q, f3_q, fo_q;
  logic [1:0]                    unit0_q, unit1_q, unit2_q, unit3_q;
  logic [ACC_W-1:0]              ang0_q, spd0_q;
  logic [BASE_W-1:0]             base1_q, base2_q, base3_q;
  logic [BASE_W-1:0]             xa1_q;
  logic [ACC_W-1:0]              basen2_q, basen3_q;
  logic [nwsp_pkg::K_NUM_W-1:0]  numk2_q;
  logic [nwsp_pkg::NR_W-1:0]     rn2_q;
  logic [ANG_P_W-1:0]            prod_a2_q;
  logic [nwsp_pkg::K_PROD_W-1:0] prodk3_q;
  logic [nwsp_pkg::N_PP_W-1:0]   plo3_q, phi3_q;
  logic [nwsp_pkg::ANGLE_W-1:0]  ang3_q, angle_q;
  logic [nwsp_pkg::SPEED_W-1:0]  speed_q;

  logic [SPD_W-1:0]              base_full;
  logic [BASE_W-1:0]             base_c;
  logic [ACC_W-1:0]              basen_c;
  logic [ANG_P_W-1:0]            ang_sh;
  logic [nwsp_pkg::N_SUM_W-1:0]  nsum;
  logic [BASE_W-1:0]             qn_sum;
  logic [BASE_W-1:0]             qk;
  logic [BASE_W-1:0]             speed_sel;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    logic       dig;
    logic [3:0] dval;
    logic       nw;
    logic       nm;
    logic [4:0] h;

    phase_d   = phase_q;
    pos_d     = pos_q;
    xor_d     = xor_q;
    acc_d     = acc_q;
    fdc_d     = fdc_q;
    point_d   = point_q;
    ang_raw_d = ang_raw_q;
    spd_raw_d = spd_raw_q;
    unit_d    = unit_q;
    flags_d   = flags_q;
    job_fire  = 1'b0;

    dig  = (char_byte_i >= nwsp_pkg::CH_ZERO) && (char_byte_i <= nwsp_pkg::CH_NINE);
    dval = 4'(char_byte_i - nwsp_pkg::CH_ZERO);
    nw   = flags_q.not_warn || (char_byte_i != nwsp_pkg::warn_char(pos_q[3:0]));
    nm   = flags_q.not_mwv || ((pos_q >= 7'd3) &&
           (char_byte_i != nwsp_pkg::mwv_char(2'(pos_q - 7'd3))));
    h    = nwsp_pkg::hex_value(char_byte_i);

    job_flags.ok    = !flags_q.reject && (phase_q == nwsp_pkg::PH_TAIL);
    job_flags.warn  = job_flags.ok && !flags_q.not_warn;
    job_flags.valid = job_flags.ok && !job_flags.warn && !flags_q.data_fail;
    job_flags.alarm = job_flags.warn && flags_q.alarm;

    if (in_fire) begin
      if (char_byte_i == nwsp_pkg::CH_NUL) begin
        job_fire  = 1'b1;
        phase_d   = nwsp_pkg::PH_HEAD;
        pos_d     = '0;
        xor_d     = '0;
        acc_d     = '0;
        fdc_d     = '0;
        point_d   = 1'b0;
        ang_raw_d = '0;
        spd_raw_d = '0;
        unit_d    = nwsp_pkg::UNIT_M;
        flags_d   = '0;
      end else begin
        if (pos_q != nwsp_pkg::POS_SAT) begin
          pos_d = pos_q + 7'd1;
        end
        if (!flags_q.reject) begin
          if (pos_q >= 7'd7 && pos_q <= 7'd11 &&
              char_byte_i != nwsp_pkg::warn_char(pos_q[3:0])) begin
            flags_d.alarm = 1'b1;
          end
          unique case (phase_q)
            nwsp_pkg::PH_HEX1: begin
              if (h != {1'b0, xor_q[7:4]}) begin
                flags_d.reject = 1'b1;
              end else begin
                phase_d = nwsp_pkg::PH_HEX2;
              end
            end
            nwsp_pkg::PH_HEX2: begin
              if (h != {1'b0, xor_q[3:0]}) begin
                flags_d.reject = 1'b1;
              end else begin
                phase_d = nwsp_pkg::PH_TAIL;
              end
            end
            nwsp_pkg::PH_TAIL: begin
            end
            default: begin
              if (pos_q == '0) begin
                if (char_byte_i != nwsp_pkg::CH_DOLLAR) begin
                  flags_d.reject = 1'b1;
                end
              end else if (pos_q >= nwsp_pkg::POS_W'(MAX_LEN)) begin
                flags_d.reject = 1'b1;
              end else if (char_byte_i == nwsp_pkg::CH_STAR) begin
                if (phase_q == nwsp_pkg::PH_DONE) begin
                  phase_d = nwsp_pkg::PH_HEX1;
                end else begin
                  flags_d.reject = 1'b1;
                end
              end else begin
                xor_d = xor_q ^ char_byte_i;
                case (phase_q)
                  nwsp_pkg::PH_HEAD: begin
                    flags_d.not_warn = nw;
                    flags_d.not_mwv  = nm;
                    if (pos_q == 7'd6) begin
                      if (!nw) begin
                        phase_d = nwsp_pkg::PH_DONE;
                      end else if (nm) begin
                        flags_d.reject = 1'b1;
                      end else begin
                        phase_d = nwsp_pkg::PH_A_FIRST;
                      end
                    end
                  end
                  nwsp_pkg::PH_A_FIRST, nwsp_pkg::PH_S_FIRST: begin
                    if (char_byte_i == nwsp_pkg::CH_COMMA) begin
                      flags_d.data_fail = 1'b1;
                      phase_d = (phase_q == nwsp_pkg::PH_A_FIRST) ?
                                nwsp_pkg::PH_REF : nwsp_pkg::PH_UNIT;
                    end else begin
                      acc_d   = '0;
                      fdc_d   = '0;
                      point_d = 1'b0;
                      phase_d = (phase_q == nwsp_pkg::PH_A_FIRST) ?
                                nwsp_pkg::PH_A_NUM : nwsp_pkg::PH_S_NUM;
                      if (dig) begin
                        acc_d = ACC_W'(dval);
                      end else if (char_byte_i == nwsp_pkg::CH_DOT) begin
                        point_d = 1'b1;
                      end else begin
                        flags_d.reject = 1'b1;
                      end
                    end
                  end
                  nwsp_pkg::PH_A_NUM, nwsp_pkg::PH_S_NUM: begin
                    if (dig) begin
                      if (!point_q) begin
                        acc_d = nwsp_pkg::mul10_add(acc_q, dval);
                      end else if (fdc_q < 2'(FRAC_DIGITS)) begin
                        acc_d = nwsp_pkg::mul10_add(acc_q, dval);
                        fdc_d = fdc_q + 2'd1;
                      end
                    end else if (char_byte_i == nwsp_pkg::CH_DOT) begin
                      if (point_q) begin
                        flags_d.reject = 1'b1;
                      end
                      point_d = 1'b1;
                    end else if (char_byte_i == nwsp_pkg::CH_COMMA) begin
                      if (phase_q == nwsp_pkg::PH_A_NUM) begin
                        ang_raw_d = pad_frac(acc_q, fdc_q);
                        phase_d   = nwsp_pkg::PH_REF;
                      end else begin
                        spd_raw_d = pad_frac(acc_q, fdc_q);
                        phase_d   = nwsp_pkg::PH_UNIT;
                      end
                    end else begin
                      flags_d.reject = 1'b1;
                    end
                  end
                  nwsp_pkg::PH_REF: begin
                    if (char_byte_i == nwsp_pkg::CH_R) begin
                      phase_d = nwsp_pkg::PH_REF_COMMA;
                    end else begin
                      flags_d.reject = 1'b1;
                    end
                  end
                  nwsp_pkg::PH_REF_COMMA: begin
                    if (char_byte_i == nwsp_pkg::CH_COMMA) begin
                      phase_d = nwsp_pkg::PH_S_FIRST;
                    end else begin
                      flags_d.reject = 1'b1;
                    end
                  end
                  nwsp_pkg::PH_UNIT: begin
                    if (char_byte_i == nwsp_pkg::CH_M) begin
                      unit_d = nwsp_pkg::UNIT_M;
                    end else if (char_byte_i == nwsp_pkg::CH_K) begin
                      unit_d = nwsp_pkg::UNIT_K;
                    end else if (char_byte_i == nwsp_pkg::CH_N) begin
                      unit_d = nwsp_pkg::UNIT_N;
                    end else begin
                      flags_d.reject = 1'b1;
                    end
                    phase_d = nwsp_pkg::PH_UNIT_COMMA;
                  end
                  nwsp_pkg::PH_UNIT_COMMA: begin
                    if (char_byte_i == nwsp_pkg::CH_COMMA) begin
                      phase_d = nwsp_pkg::PH_STATUS;
                    end else begin
                      flags_d.reject = 1'b1;
                    end
                  end
                  nwsp_pkg::PH_STATUS: begin
                    if (char_byte_i == nwsp_pkg::CH_V) begin
                      flags_d.data_fail = 1'b1;
                    end else if (char_byte_i != nwsp_pkg::CH_A) begin
                      flags_d.reject = 1'b1;
                    end
                    phase_d = nwsp_pkg::PH_DONE;
                  end
                  default: begin
                  end
                endcase
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= nwsp_pkg::PH_HEAD;
      pos_q     <= '0;
      xor_q     <= '0;
      acc_q     <= '0;
      fdc_q     <= '0;
      point_q   <= 1'b0;
      ang_raw_q <= '0;
      spd_raw_q <= '0;
      unit_q    <= nwsp_pkg::UNIT_M;
      flags_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      xor_q     <= xor_d;
      acc_q     <= acc_d;
      fdc_q     <= fdc_d;
      point_q   <= point_d;
      ang_raw_q <= ang_raw_d;
      spd_raw_q <= spd_raw_d;
      unit_q    <= unit_d;
      flags_q   <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v0_q        <= job_fire;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_comb begin
    base_full = SPD_W'(spd0_q) * SPD_W'(SPD_SCALE);
    base_c    = (base_full > SPD_W'(nwsp_pkg::BASE_MAX)) ? nwsp_pkg::BASE_MAX
                                                         : base_full[BASE_W-1:0];
    basen_c   = (base1_q > BASE_W'(nwsp_pkg::ACC_MAX)) ? nwsp_pkg::ACC_MAX
                                                       : base1_q[ACC_W-1:0];
    ang_sh    = prod_a2_q >> ANG_SHIFT;
    nsum      = (nwsp_pkg::N_SUM_W'(phi3_q) << nwsp_pkg::NR_HALF) +
                nwsp_pkg::N_SUM_W'(plo3_q);
    qn_sum    = (BASE_W'(basen3_q) + BASE_W'(nsum >> nwsp_pkg::N_SHIFT) + BASE_W'(1)) >> 1;
    qk        = BASE_W'(prodk3_q >> nwsp_pkg::K_SHIFT);
    unique case (unit3_q)
      nwsp_pkg::UNIT_K: speed_sel = qk;
      nwsp_pkg::UNIT_N: speed_sel = qn_sum;
      default:          speed_sel = base3_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (job_fire) begin
        f0_q    <= job_flags;
        unit0_q <= unit_q;
        ang0_q  <= ang_raw_q;
        spd0_q  <= spd_raw_q;
      end
      f1_q      <= f0_q;
      unit1_q   <= unit0_q;
      base1_q   <= base_c;
      xa1_q     <= BASE_W'(ang0_q) + BASE_W'(ANG_HALF);

      f2_q      <= f1_q;
      unit2_q   <= unit1_q;
      base2_q   <= base1_q;
      basen2_q  <= basen_c;
      numk2_q   <= nwsp_pkg::K_NUM_W'(base1_q) * nwsp_pkg::K_NUM_W'(nwsp_pkg::K_SCALE) +
                   nwsp_pkg::K_NUM_W'(nwsp_pkg::K_ROUND);
      rn2_q     <= nwsp_pkg::NR_W'(basen_c) * nwsp_pkg::NR_W'(nwsp_pkg::N_GAIN);
      prod_a2_q <= ANG_P_W'(xa1_q) * ANG_P_W'(ANG_MUL);

      f3_q      <= f2_q;
      unit3_q   <= unit2_q;
      base3_q   <= base2_q;
      basen3_q  <= basen2_q;
      prodk3_q  <= nwsp_pkg::K_PROD_W'(numk2_q) * nwsp_pkg::K_PROD_W'(nwsp_pkg::K_MUL);
      plo3_q    <= nwsp_pkg::N_PP_W'(rn2_q[nwsp_pkg::NR_HALF-1:0]) *
                   nwsp_pkg::N_PP_W'(nwsp_pkg::N_MUL);
      phi3_q    <= nwsp_pkg::N_PP_W'(rn2_q[nwsp_pkg::NR_W-1:nwsp_pkg::NR_HALF]) *
                   nwsp_pkg::N_PP_W'(nwsp_pkg::N_MUL);
      ang3_q    <= (ang_sh > ANG_P_W'(nwsp_pkg::ANGLE_MAX)) ? nwsp_pkg::ANGLE_MAX
                                                            : ang_sh[nwsp_pkg::ANGLE_W-1:0];

      fo_q      <= f3_q;
      if (!f3_q.valid) begin
        speed_q <= '0;
        angle_q <= '0;
      end else begin
        speed_q <= (speed_sel > BASE_W'(nwsp_pkg::SPEED_MAX)) ? nwsp_pkg::SPEED_MAX
                                                              : speed_sel[nwsp_pkg::SPEED_W-1:0];
        angle_q <= ang3_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = fo_q.ok;
  assign sentence_kind_o  = fo_q.warn;
  assign data_valid_o     = fo_q.valid;
  assign angle_alarm_o    = fo_q.alarm;
  assign speed_mm_per_s_o = speed_q;
  assign angle_deg_o      = angle_q;

endmodule

// ===== src/nwsp_checker.sv =====
// Port-level assertions for the wind sentence parser and their binding to the top level.
module nwsp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         accepted_o,
  input logic                         sentence_kind_o,
  input logic                         data_valid_o,
  input logic [nwsp_pkg::SPEED_W-1:0] speed_mm_per_s_o,
  input logic [nwsp_pkg::ANGLE_W-1:0] angle_deg_o,
  input logic                         angle_alarm_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
    $stable({accepted_o, sentence_kind_o, data_valid_o, speed_mm_per_s_o,
             angle_deg_o, angle_alarm_o}))
    else $error("Result item changed while stalled.");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> !sentence_kind_o && !data_valid_o &&
    speed_mm_per_s_o == '0 && angle_deg_o == '0 && !angle_alarm_o)
    else $error("Rejected sentence carries non-zero fields.");

  a_warn_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sentence_kind_o |-> accepted_o && !data_valid_o &&
    speed_mm_per_s_o == '0 && angle_deg_o == '0)
    else $error("Warning sentence carries wind data.");

  a_invalid_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_valid_o && !sentence_kind_o |->
    speed_mm_per_s_o == '0 && angle_deg_o == '0 && !angle_alarm_o)
    else $error("Invalid wind data carries non-zero fields.");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled without a waiting result item.");

endmodule

bind nmea_wind_sentence_parser_core nwsp_checker u_nwsp_checker (.*);
